FILE: src/min_coin_combination_unit_defines.svh
// Assertion macros for the minimum coin change unit.
// Used by min_coin_combination_unit; expects aclk and aresetn in scope.
`ifndef MIN_COIN_COMBINATION_UNIT_DEFINES_SVH
`define MIN_COIN_COMBINATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MCC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define MCC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define MCC_ASSERT_IMP(lbl, pre, post, msg)
`define MCC_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

FILE: src/mcc_pkg.sv
// Package for the minimum coin change unit: widths, defaults, FSM states,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package mcc_pkg;
    localparam int COIN_W       = 12;
    localparam int TARGET_W     = 12;
    localparam int COUNT_W      = 12;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;
    localparam int MAX_COINS_DEF  = 16;
    localparam int MAX_TARGET_DEF = 4095;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_INIT,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_CHECK_RD,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_UPD,
        ST_EMIT
    } mcc_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic init_wr;
        logic fill_rd;
        logic fill_wr;
        logic check_rd;
        logic check;
        logic walk_rd;
        logic walk_upd;
        logic emit_load;
        logic emit_done;
    } mcc_cmd_t;

    typedef struct packed {
        logic tgt_over;
        logic tgt_zero;
        logic k_done;
        logic sum_last;
        logic sum_zero;
        logic rd_reach;
        logic out_free;
    } mcc_status_t;
endpackage

FILE: src/mcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: src/mcc_ctrl.sv
// Sequencer for the minimum coin change unit: load, table fill, walk-back, emit.
// Depends on mcc_pkg.
`timescale 1ns / 1ps
module mcc_ctrl
    import mcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  mcc_status_t st,
    output mcc_cmd_t    cmd
);
    mcc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_last) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = st.tgt_over ? ST_EMIT : ST_INIT;
            end
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                state_next  = st.tgt_zero ? ST_CHECK_RD : ST_FILL_RD;
            end
            ST_FILL_RD: begin
                cmd.fill_rd = 1'b1;
                if (st.k_done) begin
                    state_next = ST_FILL_WR;
                end
            end
            ST_FILL_WR: begin
                cmd.fill_wr = 1'b1;
                state_next  = st.sum_last ? ST_CHECK_RD : ST_FILL_RD;
            end
            ST_CHECK_RD: begin
                cmd.check_rd = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = st.rd_reach ? ST_WALK_RD : ST_EMIT;
            end
            ST_WALK_RD: begin
                if (st.sum_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = ST_WALK_UPD;
                end
            end
            ST_WALK_UPD: begin
                cmd.walk_upd = 1'b1;
                state_next   = ST_WALK_RD;
            end
            ST_EMIT: begin
                if (st.k_done) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_LOAD;
                end else if (st.out_free) begin
                    cmd.emit_load = 1'b1;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

FILE: src/mcc_datapath.sv
// Datapath: coin list, fewest-coins table in RAM, compare unit, tallies and
// output register. Depends on mcc_pkg and mcc_ram.
`timescale 1ns / 1ps
module mcc_datapath
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = MAX_COINS_DEF,
    parameter int MAX_TARGET = MAX_TARGET_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mcc_cmd_t             cmd,
    output mcc_status_t          st,
    input  logic [COIN_W-1:0]    in_coin,
    input  logic [TARGET_W-1:0]  in_target,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [M_TDATA_W-1:0] out_data,
    output logic                 out_last
);
    localparam int IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam int SUM_W = $clog2(MAX_TARGET + 1);
    localparam int TW    = 1 + SUM_W + IDX_W;
    localparam int PAD_W = M_TDATA_W - 2 * COIN_W - 1;

    logic [COIN_W-1:0]   coin_store_reg [MAX_COINS];
    logic [COUNT_W-1:0]  tally_reg [MAX_COINS];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    best_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic                ok_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                found_reg;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic              tbl_we;
    logic [SUM_W-1:0]  tbl_waddr;
    logic [TW-1:0]     tbl_wdata;
    logic [SUM_W-1:0]  tbl_raddr;
    logic [TW-1:0]     tbl_rdata;
    logic              rd_reach;
    logic [SUM_W-1:0]  rd_few;
    logic [IDX_W-1:0]  rd_pick;

    logic [IDX_W-1:0]  sel_idx;
    logic [COIN_W-1:0] sel_coin;
    logic [COUNT_W-1:0] sel_tally;
    logic              coin_ok;
    logic [SUM_W:0]    cand;
    logic              better;
    logic              k_done;

    assign {rd_reach, rd_few, rd_pick} = tbl_rdata;

    assign k_done    = (k_reg == count_reg);
    assign sel_idx   = cmd.walk_upd ? rd_pick : k_reg[IDX_W-1:0];
    assign sel_coin  = coin_store_reg[sel_idx];
    assign sel_tally = tally_reg[sel_idx];
    assign coin_ok   = (sel_coin != '0) && (32'(sel_coin) <= 32'(sum_reg));
    assign cand      = {1'b0, rd_few} + (SUM_W+1)'(1);
    assign better    = pend_reg && rd_reach && (!ok_reg || (cand < {1'b0, best_reg}));

    always_comb begin
        tbl_we    = cmd.init_wr | cmd.fill_wr;
        tbl_waddr = cmd.init_wr ? '0 : sum_reg;
        tbl_wdata = cmd.init_wr ? {1'b1, {SUM_W{1'b0}}, {IDX_W{1'b0}}}
                                : {ok_reg, (ok_reg ? best_reg : {SUM_W{1'b0}}), pick_reg};
        if (cmd.check_rd) begin
            tbl_raddr = SUM_W'(target_reg);
        end else if (cmd.walk_rd) begin
            tbl_raddr = sum_reg;
        end else begin
            tbl_raddr = SUM_W'(32'(sum_reg) - 32'(sel_coin));
        end
    end

    mcc_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_TARGET + 1)
    ) u_table (
        .clk   (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && (32'(count_reg) < MAX_COINS)) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit_done) begin
                count_reg <= '0;
            end
            if (cmd.emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (32'(count_reg) < MAX_COINS) begin
                coin_store_reg[count_reg[IDX_W-1:0]] <= in_coin;
            end
            target_reg <= in_target;
        end
        if (cmd.start) begin
            for (int i = 0; i < MAX_COINS; i++) begin
                tally_reg[i] <= '0;
            end
            k_reg     <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.init_wr) begin
            sum_reg  <= SUM_W'(1);
            k_reg    <= '0;
            ok_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        if (cmd.fill_rd) begin
            if (better) begin
                ok_reg   <= 1'b1;
                best_reg <= cand[SUM_W-1:0];
                pick_reg <= pend_idx_reg;
            end
            if (!k_done) begin
                pend_reg     <= coin_ok;
                pend_idx_reg <= k_reg[IDX_W-1:0];
                k_reg        <= k_reg + CNT_W'(1);
            end else begin
                pend_reg <= 1'b0;
            end
        end
        if (cmd.fill_wr) begin
            sum_reg  <= sum_reg + SUM_W'(1);
            k_reg    <= '0;
            ok_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        if (cmd.check_rd) begin
            sum_reg <= SUM_W'(target_reg);
        end
        if (cmd.check) begin
            found_reg <= rd_reach;
            k_reg     <= '0;
        end
        if (cmd.walk_upd) begin
            tally_reg[sel_idx] <= sel_tally + COUNT_W'(1);
            sum_reg            <= SUM_W'(32'(sum_reg) - 32'(sel_coin));
        end
        if (cmd.emit_load) begin
            out_data_reg <= {{PAD_W{1'b0}}, found_reg, sel_tally, sel_coin};
            out_last_reg <= (32'(k_reg) + 1 == 32'(count_reg));
            k_reg        <= k_reg + CNT_W'(1);
        end
    end

    assign st.tgt_over = (32'(target_reg) > MAX_TARGET);
    assign st.tgt_zero = (target_reg == '0);
    assign st.k_done   = k_done;
    assign st.sum_last = (32'(sum_reg) == 32'(target_reg));
    assign st.sum_zero = (sum_reg == '0);
    assign st.rd_reach = rd_reach;
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
endmodule

FILE: src/min_coin_combination_unit.sv
// Minimum coin change unit. Coins arrive one per beat; the beat with tlast set
// carries the target and starts a run. A run fills a fewest-coins table from
// sum 0 up to the target in a RAM with separate read and write ports, one read
// per coin per sum; the walk-back reads the table and updates one tally per
// coin used, then one result beat per loaded coin goes out in load order
// (coin, use count, found flag, tlast on the final coin). Ties go to the
// lowest coin index. Targets above MAX_TARGET report not found. Coins beyond
// MAX_COINS are dropped. New coins are taken once the final result is loaded.
// Depends on mcc_pkg, mcc_ctrl, mcc_datapath, mcc_ram and the defines header.
`timescale 1ns / 1ps
`include "min_coin_combination_unit_defines.svh"
module min_coin_combination_unit
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = MAX_COINS_DEF,
    parameter int MAX_TARGET = MAX_TARGET_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [11:0] coin_value, [23:12] target_sum
    input  logic                 s_tlast,  // last_coin
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [11:0] coin_echo, [23:12] use_count,
                                           // [24] found, [31:25] zero
    output logic                 m_tlast   // last_result
);
    mcc_cmd_t    cmd;
    mcc_status_t st;

    mcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mcc_datapath #(
        .MAX_COINS  (MAX_COINS),
        .MAX_TARGET (MAX_TARGET)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .in_coin   (s_tdata[COIN_W-1:0]),
        .in_target (s_tdata[COIN_W+TARGET_W-1:COIN_W]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    `MCC_ASSERT_NXT(a_run_starts, s_tvalid && s_tready && s_tlast, !s_tready, "run did not start")
    `MCC_ASSERT_NXT(a_emit_busy, m_tvalid && m_tready && !m_tlast, !s_tready, "input open mid-emit")
    `MCC_ASSERT_IMP(a_nf_zero, m_tvalid && !m_tdata[24], m_tdata[23:12] == '0, "count without found")
endmodule
